// ----- src/tbrl_pkg.sv -----
`timescale 1ns / 1ps
package tbrl_pkg;

	localparam int KBPS_W  = 21;
	localparam int RATE_W  = 31;
	localparam int LEVEL_W = 41;
	localparam int ALU_W   = 42;
	localparam int BYTES_W = 24;
	localparam int NEED_W  = 34;
	localparam int WAIT_W  = 9;
	localparam int QUO_W   = 10;
	localparam int CNT_W   = 4;
	localparam int IDX_W   = 2;
	localparam int MODE_W  = 2;

	localparam logic [IDX_W-1:0] CFG_LIMIT_MODE      = 2'd0;
	localparam logic [IDX_W-1:0] CFG_MANUAL_KBPS     = 2'd1;
	localparam logic [IDX_W-1:0] CFG_BACKGROUND_KBPS = 2'd2;

	localparam logic [MODE_W-1:0] MODE_MANUAL     = 2'd1;
	localparam logic [MODE_W-1:0] MODE_BACKGROUND = 2'd2;

	localparam logic [KBPS_W-1:0] RESET_MANUAL_KBPS = 21'd1;
	localparam logic [KBPS_W-1:0] DEFAULT_BG_KBPS   = 21'd256;

	localparam logic FUNC_TICK    = 1'b0;
	localparam logic FUNC_REQUEST = 1'b1;

	localparam logic [RATE_W-1:0] MS_PER_SEC_R = 31'd1000;
	localparam logic [NEED_W-1:0] MS_PER_SEC_N = 34'd1000;
	localparam logic [QUO_W-1:0]  MAX_WAIT_Q   = 10'd500;
	localparam logic [CNT_W-1:0]  DIV_TOP_BIT  = 4'd9;

	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

	typedef struct packed {
		logic [ALU_W-1:0] res;
		logic             borrow;
	} alu_res_t;

	typedef struct packed {
		logic [RATE_W-1:0]  rate;
		logic [LEVEL_W-1:0] full;
	} cfg_t;

endpackage

// ----- src/tbrl_if.sv -----
`timescale 1ns / 1ps
interface tbrl_in_if;
	logic                          valid;
	logic                          ready;
	logic                          func;
	logic [tbrl_pkg::BYTES_W-1:0]  request_bytes;

	modport source (output valid, output func, output request_bytes, input ready);
	modport sink   (input valid, input func, input request_bytes, output ready);
endinterface

interface tbrl_out_if;
	logic                         valid;
	logic                         ready;
	logic                         granted;
	logic [tbrl_pkg::WAIT_W-1:0]  wait_ms;

	modport source (output valid, output granted, output wait_ms, input ready);
	modport sink   (input valid, input granted, input wait_ms, output ready);
endinterface

// ----- src/tbrl_alu.sv -----
`timescale 1ns / 1ps
module tbrl_alu (
	input  tbrl_pkg::alu_op_t             op,
	input  logic [tbrl_pkg::ALU_W-1:0]    a,
	input  logic [tbrl_pkg::ALU_W-1:0]    b,
	output tbrl_pkg::alu_res_t            y
);

	logic [tbrl_pkg::ALU_W-1:0] b_eff;
	logic [tbrl_pkg::ALU_W:0]   total;

	assign b_eff = (op == tbrl_pkg::ALU_SUB) ? ~b : b;
	assign total = {1'b0, a} + {1'b0, b_eff}
		+ {{tbrl_pkg::ALU_W{1'b0}}, (op == tbrl_pkg::ALU_SUB)};

	assign y.res    = total[tbrl_pkg::ALU_W-1:0];
	assign y.borrow = (op == tbrl_pkg::ALU_SUB) ? ~total[tbrl_pkg::ALU_W] : 1'b0;

endmodule

// ----- src/tbrl_core.sv -----
`timescale 1ns / 1ps
module tbrl_core (
	input  logic                clk,
	input  logic                arst_n,
	input  tbrl_pkg::cfg_t      cfg,
	input  logic                cfg_load,
	input  tbrl_pkg::cfg_t      cfg_new,
	tbrl_in_if.sink             in_ch,
	tbrl_out_if.source          out_ch
);

	typedef enum logic [6:0] {
		ST_IDLE     = 7'b0000001,
		ST_TICK_ADD = 7'b0000010,
		ST_TICK_CAP = 7'b0000100,
		ST_MUL      = 7'b0001000,
		ST_CMP      = 7'b0010000,
		ST_SHORT    = 7'b0100000,
		ST_DIV      = 7'b1000000
	} state_t;

	localparam int ALU_W  = tbrl_pkg::ALU_W;
	localparam int LVL_W  = tbrl_pkg::LEVEL_W;
	localparam int NEED_W = tbrl_pkg::NEED_W;

	state_t                          state_q;
	logic                            result_q;
	logic [tbrl_pkg::BYTES_W-1:0]    bytes_q;
	logic [ALU_W-1:0]                sum_q;
	logic [NEED_W-1:0]               need_q;
	logic [NEED_W-1:0]               rem_q;
	logic [tbrl_pkg::QUO_W-1:0]      quo_q;
	logic [tbrl_pkg::CNT_W-1:0]      cnt_q;
	logic                            grant_q;
	logic [LVL_W-1:0]                level_q;
	logic                            out_valid_q;
	logic                            granted_q;
	logic [tbrl_pkg::WAIT_W-1:0]     wait_q;

	tbrl_pkg::alu_op_t               alu_op;
	logic [ALU_W-1:0]                alu_a;
	logic [ALU_W-1:0]                alu_b;
	tbrl_pkg::alu_res_t              alu_y;
	logic [tbrl_pkg::WAIT_W-1:0]     wait_hint;
	logic                            out_free;

	tbrl_alu u_alu (
		.op (alu_op),
		.a  (alu_a),
		.b  (alu_b),
		.y  (alu_y)
	);

	// operand selection for the shared adder
	always_comb begin
		alu_op = tbrl_pkg::ALU_SUB;
		alu_a  = '0;
		alu_b  = '0;
		case (state_q)
			ST_TICK_ADD: begin
				alu_op = tbrl_pkg::ALU_ADD;
				alu_a  = ALU_W'(level_q);
				alu_b  = ALU_W'(cfg.rate);
			end
			ST_TICK_CAP: begin
				alu_a = sum_q;
				alu_b = ALU_W'(cfg.full);
			end
			ST_CMP: begin
				alu_a = ALU_W'(level_q);
				alu_b = ALU_W'(need_q);
			end
			ST_SHORT: begin
				alu_a = ALU_W'(need_q);
				alu_b = ALU_W'(level_q);
			end
			ST_DIV: begin
				alu_a = ALU_W'(rem_q);
				alu_b = ALU_W'(cfg.rate) << cnt_q;
			end
			default: begin
				alu_op = tbrl_pkg::ALU_SUB;
			end
		endcase
	end

	always_comb begin
		if (grant_q) begin
			wait_hint = '0;
		end else if (quo_q > tbrl_pkg::MAX_WAIT_Q) begin
			wait_hint = tbrl_pkg::MAX_WAIT_Q[tbrl_pkg::WAIT_W-1:0];
		end else if (quo_q == '0) begin
			wait_hint = tbrl_pkg::WAIT_W'(1);
		end else begin
			wait_hint = quo_q[tbrl_pkg::WAIT_W-1:0];
		end
	end

	assign out_free       = !out_valid_q || out_ch.ready;
	assign in_ch.ready    = (state_q == ST_IDLE) && !result_q && !cfg_load;
	assign out_ch.valid   = out_valid_q;
	assign out_ch.granted = granted_q;
	assign out_ch.wait_ms = wait_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			result_q    <= 1'b0;
			out_valid_q <= 1'b0;
			level_q     <= '0;
			bytes_q     <= '0;
			sum_q       <= '0;
			need_q      <= '0;
			rem_q       <= '0;
			quo_q       <= '0;
			cnt_q       <= '0;
			grant_q     <= 1'b0;
			granted_q   <= 1'b0;
			wait_q      <= '0;
		end else begin
			// finished word waits here until the output register is free
			if (result_q && out_free) begin
				out_valid_q <= 1'b1;
				granted_q   <= grant_q;
				wait_q      <= wait_hint;
				result_q    <= 1'b0;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cfg_load) begin
						level_q <= cfg_new.full;
					end else if (in_ch.valid && in_ch.ready) begin
						bytes_q <= in_ch.request_bytes;
						if (in_ch.func == tbrl_pkg::FUNC_TICK) begin
							if (cfg.rate != '0) begin
								state_q <= ST_TICK_ADD;
							end
						end else if (cfg.rate == '0) begin
							grant_q  <= 1'b1;
							quo_q    <= '0;
							result_q <= 1'b1;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_TICK_ADD: begin
					sum_q   <= alu_y.res;
					state_q <= ST_TICK_CAP;
				end
				ST_TICK_CAP: begin
					level_q <= alu_y.borrow ? sum_q[LVL_W-1:0] : cfg.full;
					state_q <= ST_IDLE;
				end
				ST_MUL: begin
					need_q  <= NEED_W'(bytes_q) * tbrl_pkg::MS_PER_SEC_N;
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (!alu_y.borrow) begin
						level_q  <= alu_y.res[LVL_W-1:0];
						grant_q  <= 1'b1;
						quo_q    <= '0;
						result_q <= 1'b1;
						state_q  <= ST_IDLE;
					end else begin
						state_q <= ST_SHORT;
					end
				end
				ST_SHORT: begin
					rem_q   <= alu_y.res[NEED_W-1:0];
					cnt_q   <= tbrl_pkg::DIV_TOP_BIT;
					quo_q   <= '0;
					grant_q <= 1'b0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					// restoring division, one quotient bit a cycle
					if (!alu_y.borrow) begin
						rem_q        <= alu_y.res[NEED_W-1:0];
						quo_q[cnt_q] <= 1'b1;
					end
					if (cnt_q == '0) begin
						result_q <= 1'b1;
						state_q  <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q - tbrl_pkg::CNT_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- src/token_bucket_rate_limiter_top.sv -----
`timescale 1ns / 1ps
// Token bucket byte-rate limiter. Register 0 selects the mode (0 or 3 unlimited, 1 manual,
// 2 background), registers 1 and 2 hold the manual and background rates in KiB/s; any write
// to one of them while the sequencer is idle refills the bucket to one second of tokens. A
// tick word (func 0) stands for one millisecond of refill and gives no answer; a request
// word (func 1) gives one answer: granted, or refused with a retry hint in ms (1 to 500).
// Additions, subtractions and compares run through one shared 42-bit adder under a small
// sequencer. With a nonzero rate a tick passes an add and a cap step; a request passes a
// multiply and a compare step, and a refused one then a shortfall step and a ten-step
// restoring division for the hint. In unlimited mode a request is granted straight from
// idle. A stalled output holds back the next word; none is taken while one is in work.
module token_bucket_rate_limiter_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [tbrl_pkg::IDX_W-1:0]       cfg_index,
	input  logic [tbrl_pkg::KBPS_W-1:0]      cfg_data,
	tbrl_in_if.sink                          in_ch,
	tbrl_out_if.source                       out_ch
);

	localparam int KBPS_W = tbrl_pkg::KBPS_W;

	logic [tbrl_pkg::MODE_W-1:0]  mode_q;
	logic [KBPS_W-1:0]            manual_q;
	logic [KBPS_W-1:0]            bg_q;
	tbrl_pkg::cfg_t               cfg_q;

	logic [tbrl_pkg::MODE_W-1:0]  mode_d;
	logic [KBPS_W-1:0]            manual_d;
	logic [KBPS_W-1:0]            bg_d;
	logic [KBPS_W-1:0]            kbps;
	logic                         cfg_load;
	tbrl_pkg::cfg_t               cfg_d;

	always_comb begin
		mode_d   = mode_q;
		manual_d = manual_q;
		bg_d     = bg_q;
		cfg_load = 1'b0;
		if (cfg_we) begin
			case (cfg_index)
				tbrl_pkg::CFG_LIMIT_MODE: begin
					mode_d   = cfg_data[tbrl_pkg::MODE_W-1:0];
					cfg_load = 1'b1;
				end
				tbrl_pkg::CFG_MANUAL_KBPS: begin
					manual_d = cfg_data;
					cfg_load = 1'b1;
				end
				tbrl_pkg::CFG_BACKGROUND_KBPS: begin
					bg_d     = cfg_data;
					cfg_load = 1'b1;
				end
				default: begin
					cfg_load = 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		case (mode_d)
			tbrl_pkg::MODE_MANUAL: begin
				kbps = (manual_d == '0) ? KBPS_W'(1) : manual_d;
			end
			tbrl_pkg::MODE_BACKGROUND: begin
				kbps = (bg_d == '0) ? tbrl_pkg::DEFAULT_BG_KBPS : bg_d;
			end
			default: begin
				kbps = '0;
			end
		endcase
	end

	assign cfg_d.rate = {kbps, 10'b0};
	assign cfg_d.full = {tbrl_pkg::RATE_W'(kbps) * tbrl_pkg::MS_PER_SEC_R, 10'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= '0;
			manual_q <= tbrl_pkg::RESET_MANUAL_KBPS;
			bg_q     <= tbrl_pkg::DEFAULT_BG_KBPS;
			cfg_q    <= '0;
		end else if (cfg_load) begin
			mode_q   <= mode_d;
			manual_q <= manual_d;
			bg_q     <= bg_d;
			cfg_q    <= cfg_d;
		end
	end

	tbrl_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.cfg_load (cfg_load),
		.cfg_new  (cfg_d),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

endmodule

// ----- sim/token_bucket_rate_limiter_top_test.sv -----
`timescale 1ns / 1ps
module token_bucket_rate_limiter_top_test;
	import tbrl_pkg::*;

	localparam logic [IDX_W-1:0]  CFG_UNUSED_IDX = 2'd3;
	localparam logic [MODE_W-1:0] MODE_UNLIMITED = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SPARE     = 2'd3;

	localparam longint unsigned KIB       = 1024;
	localparam longint unsigned MILLI     = 1000;
	localparam longint unsigned WAIT_CAP  = 500;
	localparam longint unsigned BYTES_MAX = 24'hFFFFFF;
	localparam logic [KBPS_W-1:0] KBPS_ALL = '1;

	localparam int DRAIN_CYCLES   = 24;
	localparam int TAIL_CYCLES    = 40;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_OFF_LEN   = 300;

	typedef struct packed {
		logic              granted;
		logic [WAIT_W-1:0] wait_ms;
	} grant_verdict_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [IDX_W-1:0]    cfg_index;
	logic [KBPS_W-1:0]   cfg_data;

	tbrl_in_if  in_ch();
	tbrl_out_if out_ch();

	token_bucket_rate_limiter_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// shadow of the limiter
	logic [MODE_W-1:0]  mode_now;
	logic [KBPS_W-1:0]  manual_now;
	logic [KBPS_W-1:0]  backgr_now;
	longint unsigned    fill_mb_per_ms;
	longint unsigned    bucket_mb;

	grant_verdict_t verdicts_due[$];

	bit idling          = 1'b1;
	bit offering        = 1'b0;
	int hold_off_cycles = 0;
	int failures        = 0;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	task automatic report_mismatch(input string what);
		failures++;
		if (failures <= 40)
			$display("%0t ns mismatch: %s", $time, what);
	endtask

	function automatic void retune_bucket();
		longint unsigned kbps;
		case (mode_now)
			MODE_MANUAL: begin
				kbps = manual_now;
				if (kbps == 0)
					kbps = 1;
				fill_mb_per_ms = kbps * KIB;
			end
			MODE_BACKGROUND: begin
				kbps = backgr_now;
				if (kbps == 0)
					kbps = DEFAULT_BG_KBPS;
				fill_mb_per_ms = kbps * KIB;
			end
			default: begin
				fill_mb_per_ms = 0;
			end
		endcase
		bucket_mb = fill_mb_per_ms * MILLI;
	endfunction

	function automatic void judge_word(input logic f, input logic [BYTES_W-1:0] b);
		longint unsigned need;
		longint unsigned hint;
		grant_verdict_t  v;
		if (f == FUNC_TICK) begin
			if (fill_mb_per_ms != 0) begin
				bucket_mb += fill_mb_per_ms;
				if (bucket_mb > fill_mb_per_ms * MILLI)
					bucket_mb = fill_mb_per_ms * MILLI;
			end
			return;
		end
		v.granted = 1'b1;
		v.wait_ms = '0;
		need = b;
		need = need * MILLI;
		if (fill_mb_per_ms != 0) begin
			if (bucket_mb >= need) begin
				bucket_mb -= need;
			end else begin
				hint = (need - bucket_mb) / fill_mb_per_ms;
				if (hint > WAIT_CAP)
					hint = WAIT_CAP;
				if (hint < 1)
					hint = 1;
				v.granted = 1'b0;
				v.wait_ms = hint[WAIT_W-1:0];
			end
		end
		verdicts_due.push_back(v);
	endfunction

	function automatic logic [KBPS_W-1:0] pick_kbps();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return KBPS_W'(1);
			2: return KBPS_W'(1048576);
			3: return KBPS_ALL;
			4: return KBPS_W'($urandom_range(2, 64));
			default: return KBPS_W'($urandom);
		endcase
	endfunction

	// returns at the edge where the word is taken
	task automatic offer_word(input logic f, input logic [BYTES_W-1:0] b);
		if (idling && $urandom_range(0, 3) == 0) begin
			if (offering)
				in_ch.valid <= 1'b0;
			offering = 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		in_ch.valid         <= 1'b1;
		in_ch.func          <= f;
		in_ch.request_bytes <= b;
		offering = 1'b1;
		do
			@(posedge clk);
		while (in_ch.ready !== 1'b1);
		judge_word(f, b);
	endtask

	task automatic withdraw_word();
		if (offering)
			in_ch.valid <= 1'b0;
		offering = 1'b0;
	endtask

	// a tick leaves no answer behind, so give it time to finish too
	task automatic drain_block();
		withdraw_word();
		do
			@(posedge clk);
		while (verdicts_due.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [KBPS_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx != CFG_UNUSED_IDX) begin
			case (idx)
				CFG_LIMIT_MODE:  mode_now   = data[MODE_W-1:0];
				CFG_MANUAL_KBPS: manual_now = data;
				default:         backgr_now = data;
			endcase
			retune_bucket();
		end
	endtask

	task automatic test_directed_cases();
		// unlimited straight after reset
		offer_word(FUNC_REQUEST, '0);
		offer_word(FUNC_REQUEST, BYTES_W'(BYTES_MAX));
		offer_word(FUNC_TICK, BYTES_W'(BYTES_MAX));
		drain_block();
		write_reg(CFG_MANUAL_KBPS, '0);
		write_reg(CFG_LIMIT_MODE, {19'h7FFFF, MODE_MANUAL});
		offer_word(FUNC_TICK, '0);
		offer_word(FUNC_REQUEST, 24'd1024);
		offer_word(FUNC_REQUEST, '0);
		offer_word(FUNC_REQUEST, 24'd1);
		offer_word(FUNC_TICK, '0);
		offer_word(FUNC_REQUEST, 24'd1);
		offer_word(FUNC_REQUEST, BYTES_W'(BYTES_MAX));
		drain_block();
		// unused index must not refill
		write_reg(CFG_UNUSED_IDX, KBPS_ALL);
		offer_word(FUNC_REQUEST, 24'd2);
		offer_word(FUNC_REQUEST, 24'd100);
		drain_block();
		write_reg(CFG_BACKGROUND_KBPS, '0);
		write_reg(CFG_LIMIT_MODE, KBPS_W'(MODE_BACKGROUND));
		offer_word(FUNC_REQUEST, 24'd262144);
		offer_word(FUNC_REQUEST, 24'd262145);
		offer_word(FUNC_REQUEST, 24'd100);
		drain_block();
		write_reg(CFG_LIMIT_MODE, KBPS_W'(MODE_SPARE));
		offer_word(FUNC_REQUEST, BYTES_W'(BYTES_MAX));
		offer_word(FUNC_TICK, '0);
		drain_block();
		write_reg(CFG_MANUAL_KBPS, KBPS_ALL);
		write_reg(CFG_LIMIT_MODE, KBPS_W'(MODE_MANUAL));
		offer_word(FUNC_REQUEST, BYTES_W'(BYTES_MAX));
		offer_word(FUNC_TICK, '0);
		drain_block();
		write_reg(CFG_BACKGROUND_KBPS, KBPS_W'(1048576));
		write_reg(CFG_LIMIT_MODE, KBPS_W'(MODE_BACKGROUND));
		offer_word(FUNC_REQUEST, BYTES_W'(BYTES_MAX));
		offer_word(FUNC_REQUEST, 24'd1);
		drain_block();
	endtask

	task automatic test_output_backpressure();
		int n;
		drain_block();
		write_reg(CFG_MANUAL_KBPS, KBPS_W'(3));
		write_reg(CFG_LIMIT_MODE, KBPS_W'(MODE_MANUAL));
		hold_off_cycles = HOLD_OFF_LEN;
		for (n = 0; n < 40; n++) begin
			if ($urandom_range(0, 4) == 0)
				offer_word(FUNC_TICK, BYTES_W'($urandom));
			else
				offer_word(FUNC_REQUEST, BYTES_W'($urandom_range(0, 4000)));
		end
		drain_block();
	endtask

	task automatic test_random_traffic(input int phases, input int words);
		int                 p;
		int                 n;
		logic [KBPS_W-1:0]  mode_word;
		longint unsigned    avail;
		longint unsigned    ask;
		for (p = 0; p < phases; p++) begin
			drain_block();
			if ($urandom_range(0, 2) != 0)
				write_reg(CFG_MANUAL_KBPS, pick_kbps());
			if ($urandom_range(0, 2) != 0)
				write_reg(CFG_BACKGROUND_KBPS, pick_kbps());
			if ($urandom_range(0, 5) == 0)
				write_reg(CFG_UNUSED_IDX, KBPS_W'($urandom));
			mode_word = KBPS_W'($urandom);
			case ($urandom_range(0, 9))
				0:          mode_word[MODE_W-1:0] = MODE_UNLIMITED;
				1:          mode_word[MODE_W-1:0] = MODE_SPARE;
				2, 3, 4, 5: mode_word[MODE_W-1:0] = MODE_MANUAL;
				default:    mode_word[MODE_W-1:0] = MODE_BACKGROUND;
			endcase
			write_reg(CFG_LIMIT_MODE, mode_word);
			for (n = 0; n < words; n++) begin
				if ($urandom_range(0, 9) < 6) begin
					offer_word(FUNC_TICK, BYTES_W'($urandom));
				end else begin
					avail = bucket_mb / MILLI;
					case ($urandom_range(0, 7))
						0: ask = 0;
						1: ask = $urandom_range(0, BYTES_MAX);
						2: ask = avail;
						3: ask = avail + 1;
						4: ask = $urandom_range(0, (avail > BYTES_MAX) ? BYTES_MAX : avail);
						5: ask = avail + (fill_mb_per_ms * $urandom_range(0, 600)) / MILLI + 1;
						default: ask = (fill_mb_per_ms * $urandom_range(0, 4000)) / (MILLI * MILLI);
					endcase
					if (ask > BYTES_MAX)
						ask = BYTES_MAX;
					offer_word(FUNC_REQUEST, ask[BYTES_W-1:0]);
				end
			end
		end
		drain_block();
	endtask

	task automatic test_steady_stream();
		idling = 1'b0;
		test_random_traffic(2, 50);
	endtask

	// answer side: random stalls while idling, plus one long hold-off on request
	initial begin
		out_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off_cycles != 0) begin
				out_ch.ready <= 1'b0;
				repeat (hold_off_cycles) @(posedge clk);
				hold_off_cycles = 0;
			end else if (idling && $urandom_range(0, 5) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end else begin
				out_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		grant_verdict_t want;
		forever begin
			@(posedge clk);
			if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
				if (verdicts_due.size() == 0) begin
					report_mismatch($sformatf("answer with none due: granted %0b wait_ms %0d",
						out_ch.granted, out_ch.wait_ms));
				end else begin
					want = verdicts_due.pop_front();
					if (out_ch.granted !== want.granted)
						report_mismatch($sformatf("granted %0b, want %0b",
							out_ch.granted, want.granted));
					if (out_ch.wait_ms !== want.wait_ms)
						report_mismatch($sformatf("wait_ms %0d, want %0d",
							out_ch.wait_ms, want.wait_ms));
				end
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (arst_n !== 1'b1 || (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
			    (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
		$display("** token_bucket_rate_limiter_top: FAILED **");
		$finish;
	end

	initial begin
		arst_n              <= 1'b0;
		cfg_we              <= 1'b0;
		cfg_index           <= CFG_LIMIT_MODE;
		cfg_data            <= '0;
		in_ch.valid         <= 1'b0;
		in_ch.func          <= FUNC_TICK;
		in_ch.request_bytes <= '0;
		mode_now       = MODE_UNLIMITED;
		manual_now     = RESET_MANUAL_KBPS;
		backgr_now     = DEFAULT_BG_KBPS;
		fill_mb_per_ms = 0;
		bucket_mb      = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_cases();
		test_output_backpressure();
		test_random_traffic(8, 90);
		test_steady_stream();
		while (verdicts_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("** token_bucket_rate_limiter_top: PASSED **");
		else
			$display("** token_bucket_rate_limiter_top: FAILED **");
		$finish;
	end

endmodule
